>>> rtl/core/utf8d_pkg.sv
// Shared types, constants and helper functions for the UTF-8 stream decoder.
`timescale 1ns / 1ps

package utf8d_pkg;

  localparam int ByteWidth  = 8;
  localparam int CpWidth    = 21;
  localparam int OutTdataW  = ((CpWidth + 7) / 8) * 8;
  localparam int OutTuserW  = 2;
  localparam int IdxWidth   = 2;   // result index within one byte's results (up to four)
  localparam int QueueDepthDefault = 4;

  localparam logic [CpWidth-1:0] ReplResetValue = CpWidth'(32'h0000_FFFD);
  localparam logic [CpWidth-1:0] MaxScalar      = CpWidth'(32'h0010_FFFF);
  localparam logic [CpWidth-1:0] SurrogateLo    = CpWidth'(32'h0000_D800);
  localparam logic [CpWidth-1:0] SurrogateHi    = CpWidth'(32'h0000_DFFF);
  localparam logic [CpWidth-1:0] MinTwoByte     = CpWidth'(32'h0000_0080);
  localparam logic [CpWidth-1:0] MinThreeByte   = CpWidth'(32'h0000_0800);
  localparam logic [CpWidth-1:0] MinFourByte    = CpWidth'(32'h0001_0000);

  // Sequence lengths as held in the decoder state.
  localparam logic [2:0] SeqLenNone  = 3'd0;
  localparam logic [2:0] SeqLenOne   = 3'd1;
  localparam logic [2:0] SeqLenTwo   = 3'd2;
  localparam logic [2:0] SeqLenThree = 3'd3;
  localparam logic [2:0] SeqLenFour  = 3'd4;

  // One queued command: all results but the last are replacements; the last
  // one is the carried code point when final_good is set.
  typedef struct packed {
    logic [CpWidth-1:0]  cp;
    logic                final_good;
    logic [IdxWidth-1:0] last_idx;
  } utf8d_cmd_t;

  typedef struct packed {
    logic       push;
    utf8d_cmd_t cmd;
  } utf8d_push_t;

  function automatic logic in_range(input logic [CpWidth-1:0] cp,
                                    input logic [CpWidth-1:0] lo,
                                    input logic [CpWidth-1:0] hi);
    in_range = (cp >= lo) && (cp <= hi);
  endfunction

  function automatic logic is_combining(input logic [CpWidth-1:0] cp);
    is_combining = in_range(cp, CpWidth'(32'h0300), CpWidth'(32'h036F))
                || in_range(cp, CpWidth'(32'h0591), CpWidth'(32'h05BD))
                || (cp == CpWidth'(32'h05BF))
                || in_range(cp, CpWidth'(32'h05C1), CpWidth'(32'h05C2))
                || in_range(cp, CpWidth'(32'h05C4), CpWidth'(32'h05C5))
                || (cp == CpWidth'(32'h05C7))
                || in_range(cp, CpWidth'(32'h1DC0), CpWidth'(32'h1DFF))
                || in_range(cp, CpWidth'(32'h20D0), CpWidth'(32'h20FF))
                || in_range(cp, CpWidth'(32'hFE20), CpWidth'(32'hFE2F));
  endfunction

endpackage

>>> rtl/core/utf8d_front.sv
// Front end: accepts bytes, tracks the pending sequence and emits commands.
`timescale 1ns / 1ps

module utf8d_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             byte_valid,
  input  logic [utf8d_pkg::ByteWidth-1:0]  byte_data,
  input  logic                             queue_full,
  output logic                             byte_ready,
  output utf8d_pkg::utf8d_push_t           push_o
);

  logic [2:0]                      exp_len, exp_len_next;
  logic [1:0]                      seen, seen_next;
  logic [utf8d_pkg::CpWidth-1:0]   partial, partial_next;

  logic                            accept;
  logic                            pending;
  logic                            is_cont;
  logic [2:0]                      lead_len;
  logic [utf8d_pkg::CpWidth-1:0]   joined;
  logic [1:0]                      seen_inc;
  logic                            complete;
  logic                            overlong;
  logic                            bad;
  logic [2:0]                      n_res;

  assign byte_ready = !queue_full;
  assign accept     = byte_valid && byte_ready;
  assign pending    = (exp_len != utf8d_pkg::SeqLenNone);
  assign is_cont    = (byte_data[7:6] == 2'b10);

  always_comb begin
    if (!byte_data[7])                     lead_len = utf8d_pkg::SeqLenOne;
    else if (byte_data[7:5] == 3'b110)     lead_len = utf8d_pkg::SeqLenTwo;
    else if (byte_data[7:4] == 4'b1110)    lead_len = utf8d_pkg::SeqLenThree;
    else if (byte_data[7:3] == 5'b11110)   lead_len = utf8d_pkg::SeqLenFour;
    else                                   lead_len = utf8d_pkg::SeqLenNone;
  end

  assign joined   = {partial[utf8d_pkg::CpWidth-7:0], byte_data[5:0]};
  assign seen_inc = seen + 2'd1;
  assign complete = ({1'b0, seen_inc} >= exp_len) || (seen_inc == 2'd0);

  always_comb begin
    overlong = ((exp_len == utf8d_pkg::SeqLenTwo)   && (joined < utf8d_pkg::MinTwoByte))
            || ((exp_len == utf8d_pkg::SeqLenThree) && (joined < utf8d_pkg::MinThreeByte))
            || ((exp_len == utf8d_pkg::SeqLenFour)  && (joined < utf8d_pkg::MinFourByte));
    bad = overlong
       || utf8d_pkg::in_range(joined, utf8d_pkg::SurrogateLo, utf8d_pkg::SurrogateHi)
       || (joined > utf8d_pkg::MaxScalar);
  end

  always_comb begin
    exp_len_next = exp_len;
    seen_next    = seen;
    partial_next = partial;
    push_o       = '0;
    n_res        = 3'd0;
    if (accept) begin
      if (pending && is_cont) begin
        if (complete) begin
          exp_len_next = utf8d_pkg::SeqLenNone;
          seen_next    = 2'd0;
          partial_next = '0;
          n_res        = bad ? exp_len : 3'd1;
          push_o.cmd.cp         = joined;
          push_o.cmd.final_good = !bad;
        end else begin
          seen_next    = seen_inc;
          partial_next = joined;
        end
      end else begin
        // A broken sequence costs one replacement, then the byte is a lead.
        n_res = {2'b00, pending};
        push_o.cmd.cp         = utf8d_pkg::CpWidth'(byte_data);
        push_o.cmd.final_good = (lead_len == utf8d_pkg::SeqLenOne);
        exp_len_next = utf8d_pkg::SeqLenNone;
        seen_next    = 2'd0;
        partial_next = '0;
        unique case (lead_len) inside
          utf8d_pkg::SeqLenNone,
          utf8d_pkg::SeqLenOne: begin
            n_res = n_res + 3'd1;
          end
          utf8d_pkg::SeqLenTwo: begin
            exp_len_next = lead_len;
            seen_next    = 2'd1;
            partial_next = utf8d_pkg::CpWidth'(byte_data[4:0]);
          end
          utf8d_pkg::SeqLenThree: begin
            exp_len_next = lead_len;
            seen_next    = 2'd1;
            partial_next = utf8d_pkg::CpWidth'(byte_data[3:0]);
          end
          utf8d_pkg::SeqLenFour: begin
            exp_len_next = lead_len;
            seen_next    = 2'd1;
            partial_next = utf8d_pkg::CpWidth'(byte_data[2:0]);
          end
          default: begin
            n_res = n_res + 3'd1;
          end
        endcase
      end
      push_o.push         = (n_res != 3'd0);
      push_o.cmd.last_idx = 2'(n_res - 3'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      exp_len <= utf8d_pkg::SeqLenNone;
      seen    <= 2'd0;
      partial <= '0;
    end else begin
      exp_len <= exp_len_next;
      seen    <= seen_next;
      partial <= partial_next;
    end
  end

endmodule

>>> rtl/core/utf8d_fifo.sv
// Small command queue between the front end and the result emitter.
`timescale 1ns / 1ps

module utf8d_fifo #(
  parameter int Depth = utf8d_pkg::QueueDepthDefault
) (
  input  logic                    clk,
  input  logic                    rst,
  input  utf8d_pkg::utf8d_push_t  push_i,
  input  logic                    pop,
  output logic                    full,
  output logic                    not_empty,
  output utf8d_pkg::utf8d_cmd_t   head
);

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  utf8d_pkg::utf8d_cmd_t slots [Depth];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] count;
  logic            do_push, do_pop;

  assign full      = (count == CntW'(Depth));
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];
  assign do_push   = push_i.push && !full;
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_i.cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!do_push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> rtl/core/utf8d_back.sv
// Back end: turns queued commands into registered results, one per cycle unless stalled.
`timescale 1ns / 1ps

module utf8d_back (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cmd_valid,
  input  utf8d_pkg::utf8d_cmd_t            cmd,
  input  logic [utf8d_pkg::CpWidth-1:0]    repl_value,
  output logic                             cmd_pop,
  output logic                             res_valid,
  input  logic                             res_ready,
  output logic [utf8d_pkg::CpWidth-1:0]    res_cp,
  output logic                             res_replaced,
  output logic                             res_combining,
  output logic                             res_last
);

  logic [utf8d_pkg::IdxWidth-1:0] idx;
  logic                           emit;
  logic                           at_last;
  logic                           good;
  logic [utf8d_pkg::CpWidth-1:0]  cp_sel;

  assign emit    = cmd_valid && (!res_valid || res_ready);
  assign at_last = (idx == cmd.last_idx);
  assign good    = at_last && cmd.final_good;
  assign cp_sel  = good ? cmd.cp : repl_value;
  assign cmd_pop = emit && at_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (emit) begin
        res_valid <= 1'b1;
        idx       <= at_last ? '0 : idx + 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res_cp        <= cp_sel;
      res_replaced  <= !good;
      res_combining <= utf8d_pkg::is_combining(cp_sel);
      res_last      <= at_last;
    end
  end

endmodule

>>> rtl/core/utf8_stream_decoder.sv
// Top level of the UTF-8 stream decoder with validation and combining-mark flag.
`timescale 1ns / 1ps

// UTF-8 stream decoder. Takes one raw byte per transaction on the s_axis side
// and returns decoded code points on the m_axis side, one result per
// transaction. A well-formed sequence gives one result on its final byte;
// malformed input gives the programmed replacement value with tuser bit 0 set
// (one per invalid lead byte, one for a sequence cut short by a non-
// continuation byte, which is then decoded again as a lead, and one per byte
// of an overlong, surrogate or out-of-range sequence). tlast marks the final
// result caused by one input byte; bytes that only extend a sequence give
// nothing. Rate: the front end takes one byte every cycle while the command
// queue (QueueDepth entries, default 4) has room; the back end drives one
// result per cycle while m_axis_tready allows, and a byte causes one to four
// results. Even with m_axis_tready held high the queue can fill, for instance
// when a bad four-byte sequence is followed by single-result bytes, and
// s_axis_tready then drops; a stalled m_axis side fills it as well, and
// s_axis_tready stays low until the back end pops a command. With an empty
// queue a result passes from the byte through a queue slot and the output
// register. Write replacement_value through cfg_we/cfg_wdata only while no
// transaction is in flight; it resets to U+FFFD.

module utf8_stream_decoder #(
  parameter int QueueDepth = utf8d_pkg::QueueDepthDefault
) (
  input  logic                             clk,
  input  logic                             rst,
  // configuration: replacement_value
  input  logic                             cfg_we,
  input  logic [utf8d_pkg::CpWidth-1:0]    cfg_wdata,
  // input byte stream
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [utf8d_pkg::ByteWidth-1:0]  s_axis_tdata,   // [7:0] in_byte
  // decoded results
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [utf8d_pkg::OutTdataW-1:0]  m_axis_tdata,   // [20:0] codepoint, rest zero
  output logic [utf8d_pkg::OutTuserW-1:0]  m_axis_tuser,   // [0] replaced, [1] combining
  output logic                             m_axis_tlast    // last result of this byte
);

  // Replacement value register; hold between writes.
  logic [utf8d_pkg::CpWidth-1:0] repl_value;

  utf8d_pkg::utf8d_push_t push;
  utf8d_pkg::utf8d_cmd_t  head;
  logic                   queue_full;
  logic                   queue_not_empty;
  logic                   queue_pop;

  logic [utf8d_pkg::CpWidth-1:0] res_cp;
  logic                          res_replaced;
  logic                          res_combining;

  always_ff @(posedge clk) begin
    if (rst) begin
      repl_value <= utf8d_pkg::ReplResetValue;
    end else if (cfg_we) begin
      repl_value <= cfg_wdata;
    end
  end

  // Front end: classify each byte, advance the sequence state, queue results.
  utf8d_front u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (s_axis_tvalid),
    .byte_data  (s_axis_tdata),
    .queue_full (queue_full),
    .byte_ready (s_axis_tready),
    .push_o     (push)
  );

  // Command queue absorbs bytes that expand into several results.
  utf8d_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push_i    (push),
    .pop       (queue_pop),
    .full      (queue_full),
    .not_empty (queue_not_empty),
    .head      (head)
  );

  // Back end: expand each command into results and drive the output register.
  utf8d_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cmd_valid     (queue_not_empty),
    .cmd           (head),
    .repl_value    (repl_value),
    .cmd_pop       (queue_pop),
    .res_valid     (m_axis_tvalid),
    .res_ready     (m_axis_tready),
    .res_cp        (res_cp),
    .res_replaced  (res_replaced),
    .res_combining (res_combining),
    .res_last      (m_axis_tlast)
  );

  assign m_axis_tdata = utf8d_pkg::OutTdataW'(res_cp);
  assign m_axis_tuser = {res_combining, res_replaced};

endmodule

>>> dv/tb.sv
// Self-checking stream testbench for the UTF-8 stream decoder.
`timescale 1ns / 1ps

module tb;

  // Give up well past the slowest correct run.
  localparam int CycleLimit = 200000;
  // Minimum bytes of random traffic per random phase (five phases).
  localparam int PhaseBytes = 48;
  // Quiet cycles after the last result, before a register write or the end.
  localparam int SettleCycles = 8;

  // One decoded result as seen on the master side.
  typedef struct packed {
    logic [utf8d_pkg::CpWidth-1:0] cp;
    logic                          replaced;
    logic                          combining;
    logic                          is_last;
  } decoded_t;

  // Track the decoder state byte by byte and hold the code points it owes.
  class CodepointTracker;
    decoded_t                      pending_cps[$];
    logic [2:0]                    seq_len;
    logic [1:0]                    seq_seen;
    logic [utf8d_pkg::CpWidth-1:0] seq_bits;
    logic [utf8d_pkg::CpWidth-1:0] repl_cp;
    int                            errors;

    function new();
      repl_cp = utf8d_pkg::ReplResetValue;
      errors  = 0;
      clear_sequence();
    endfunction

    function void clear_sequence();
      seq_len  = utf8d_pkg::SeqLenNone;
      seq_seen = 2'd0;
      seq_bits = '0;
    endfunction

    function void set_replacement(logic [utf8d_pkg::CpWidth-1:0] v);
      repl_cp = v;
    endfunction

    function int pending();
      return pending_cps.size();
    endfunction

    function logic cp_is_mark(logic [utf8d_pkg::CpWidth-1:0] cp);
      return (cp >= 21'h000300 && cp <= 21'h00036F)
          || (cp >= 21'h000591 && cp <= 21'h0005BD)
          || (cp == 21'h0005BF)
          || (cp >= 21'h0005C1 && cp <= 21'h0005C2)
          || (cp >= 21'h0005C4 && cp <= 21'h0005C5)
          || (cp == 21'h0005C7)
          || (cp >= 21'h001DC0 && cp <= 21'h001DFF)
          || (cp >= 21'h0020D0 && cp <= 21'h0020FF)
          || (cp >= 21'h00FE20 && cp <= 21'h00FE2F);
    endfunction

    function decoded_t make_result(logic [utf8d_pkg::CpWidth-1:0] cp, logic bad);
      decoded_t r;
      r.cp        = cp;
      r.replaced  = bad;
      r.combining = cp_is_mark(cp);
      r.is_last   = 1'b0;
      return r;
    endfunction

    // Work out the results one accepted byte causes and queue them.
    function void note_byte(logic [7:0] b);
      decoded_t                      batch[4];
      int                            n;
      logic [2:0]                    len_now;
      logic [utf8d_pkg::CpWidth-1:0] cp_now;
      logic                          bad;
      n = 0;
      if (seq_len != utf8d_pkg::SeqLenNone && b[7:6] == 2'b10) begin
        seq_bits = {seq_bits[utf8d_pkg::CpWidth-7:0], b[5:0]};
        seq_seen = seq_seen + 2'd1;
        if ({1'b0, seq_seen} >= seq_len || seq_seen == 2'd0) begin
          len_now = seq_len;
          cp_now  = seq_bits;
          bad = (len_now == utf8d_pkg::SeqLenTwo && cp_now < utf8d_pkg::MinTwoByte)
             || (len_now == utf8d_pkg::SeqLenThree && cp_now < utf8d_pkg::MinThreeByte)
             || (len_now == utf8d_pkg::SeqLenFour && cp_now < utf8d_pkg::MinFourByte)
             || (cp_now >= utf8d_pkg::SurrogateLo && cp_now <= utf8d_pkg::SurrogateHi)
             || (cp_now > utf8d_pkg::MaxScalar);
          clear_sequence();
          if (bad) begin
            for (int k = 0; k < int'(len_now) && k < 4; k++) begin
              batch[n] = make_result(repl_cp, 1'b1);
              n++;
            end
          end else begin
            batch[n] = make_result(cp_now, 1'b0);
            n++;
          end
        end
      end else begin
        // Drop a broken sequence, then treat the byte as a fresh lead.
        if (seq_len != utf8d_pkg::SeqLenNone) begin
          batch[n] = make_result(repl_cp, 1'b1);
          n++;
          clear_sequence();
        end
        if (b[7] == 1'b0) begin
          batch[n] = make_result({13'd0, b}, 1'b0);
          n++;
        end else if (b[7:5] == 3'b110) begin
          seq_len  = utf8d_pkg::SeqLenTwo;
          seq_seen = 2'd1;
          seq_bits = {16'd0, b[4:0]};
        end else if (b[7:4] == 4'b1110) begin
          seq_len  = utf8d_pkg::SeqLenThree;
          seq_seen = 2'd1;
          seq_bits = {17'd0, b[3:0]};
        end else if (b[7:3] == 5'b11110) begin
          seq_len  = utf8d_pkg::SeqLenFour;
          seq_seen = 2'd1;
          seq_bits = {18'd0, b[2:0]};
        end else begin
          batch[n] = make_result(repl_cp, 1'b1);
          n++;
        end
      end
      if (n > 0) batch[n-1].is_last = 1'b1;
      for (int k = 0; k < n; k++) pending_cps.push_back(batch[k]);
    endfunction

    // Compare one accepted result with the oldest code point owed.
    function void check_codepoint(logic [utf8d_pkg::CpWidth-1:0] cp, logic replaced,
                                  logic combining, logic is_last);
      decoded_t want;
      if (pending_cps.size() == 0) begin
        $display("%0t: unexpected result cp=%h replaced=%b combining=%b last=%b",
                 $time, cp, replaced, combining, is_last);
        errors++;
        return;
      end
      want = pending_cps.pop_front();
      if (want.cp !== cp || want.replaced !== replaced ||
          want.combining !== combining || want.is_last !== is_last) begin
        $display("%0t: mismatch expected cp=%h replaced=%b combining=%b last=%b",
                 $time, want.cp, want.replaced, want.combining, want.is_last);
        $display("%0t:          actual   cp=%h replaced=%b combining=%b last=%b",
                 $time, cp, replaced, combining, is_last);
        errors++;
      end
    endfunction
  endclass

  logic                            clk = 1'b0;
  logic                            rst;
  logic                            cfg_we;
  logic [utf8d_pkg::CpWidth-1:0]   cfg_wdata;
  logic                            s_axis_tvalid;
  logic                            s_axis_tready;
  logic [utf8d_pkg::ByteWidth-1:0] s_axis_tdata;   // [7:0] in_byte
  logic                            m_axis_tvalid;
  logic                            m_axis_tready;
  logic [utf8d_pkg::OutTdataW-1:0] m_axis_tdata;   // [20:0] codepoint, rest zero
  logic [utf8d_pkg::OutTuserW-1:0] m_axis_tuser;   // [0] replaced, [1] combining
  logic                            m_axis_tlast;

  CodepointTracker tracker = new();
  logic [7:0]      byte_plan[$];
  int              idle_pct  = 0;   // chance per cycle that the sender holds off
  int              stall_pct = 0;   // chance per cycle that the receiver stalls
  int              cycle_count = 0;

  utf8_stream_decoder dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: end the run if the handshakes never finish.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("%0t: timeout with %0d results still owed", $time, tracker.pending());
      $display("TEST FAILED");
      $finish;
    end
  end

  // Receiver: check every result transaction at the rising edge, then pick
  // the next cycle's tready at the falling edge.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_axis_tvalid && m_axis_tready)
        tracker.check_codepoint(m_axis_tdata[utf8d_pkg::CpWidth-1:0], m_axis_tuser[0],
                                m_axis_tuser[1], m_axis_tlast);
      @(negedge clk);
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Offer one byte, holding off at random first; return at the falling edge
  // after the transaction. tvalid stays high into the next call, so a
  // back-to-back byte never sees it lowered and raised in one step.
  task automatic drive_byte(input logic [7:0] b);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk); while (!s_axis_tready);
    tracker.note_byte(b);
    @(negedge clk);
  endtask

  // Send every planned byte, then drop tvalid.
  task automatic drive_plan();
    while (byte_plan.size() != 0) drive_byte(byte_plan.pop_front());
    s_axis_tvalid <= 1'b0;
  endtask

  // Hold until every owed result has come, then let the pipeline settle.
  task automatic wait_drained();
    while (tracker.pending() != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  // Write replacement_value; only called with the decoder idle.
  task automatic write_replacement(input logic [utf8d_pkg::CpWidth-1:0] v);
    cfg_wdata <= v;
    cfg_we    <= 1'b1;
    @(negedge clk);
    cfg_we    <= 1'b0;
    tracker.set_replacement(v);
    @(negedge clk);
  endtask

  // Append the len-byte form of cp; overlong and out-of-range forms included.
  task automatic plan_encoded(input logic [utf8d_pkg::CpWidth-1:0] cp, input int len);
    case (len)
      1: begin
        byte_plan.push_back({1'b0, cp[6:0]});
      end
      2: begin
        byte_plan.push_back({3'b110, cp[10:6]});
        byte_plan.push_back({2'b10, cp[5:0]});
      end
      3: begin
        byte_plan.push_back({4'b1110, cp[15:12]});
        byte_plan.push_back({2'b10, cp[11:6]});
        byte_plan.push_back({2'b10, cp[5:0]});
      end
      default: begin
        byte_plan.push_back({5'b11110, cp[20:18]});
        byte_plan.push_back({2'b10, cp[17:12]});
        byte_plan.push_back({2'b10, cp[11:6]});
        byte_plan.push_back({2'b10, cp[5:0]});
      end
    endcase
  endtask

  // Append one random sequence: mostly well formed, the rest malformed or noise.
  task automatic plan_random_sequence();
    logic [utf8d_pkg::CpWidth-1:0] mark_edges[16];
    logic [utf8d_pkg::CpWidth-1:0] cp;
    int                            kind;
    int                            len;
    mark_edges = '{21'h0300, 21'h036F, 21'h0591, 21'h05BD, 21'h05BF, 21'h05C1,
                   21'h05C2, 21'h05C4, 21'h05C5, 21'h05C7, 21'h1DC0, 21'h1DFF,
                   21'h20D0, 21'h20FF, 21'hFE20, 21'hFE2F};
    kind = $urandom_range(99);
    if (kind < 16) begin
      plan_encoded(utf8d_pkg::CpWidth'($urandom_range(0, 21'h7F)), 1);
    end else if (kind < 28) begin
      plan_encoded(utf8d_pkg::CpWidth'($urandom_range(21'h80, 21'h7FF)), 2);
    end else if (kind < 42) begin
      cp = utf8d_pkg::CpWidth'($urandom_range(21'h800, 21'hFFFF));
      if (cp >= utf8d_pkg::SurrogateLo && cp <= utf8d_pkg::SurrogateHi) cp = cp - 21'h800;
      plan_encoded(cp, 3);
    end else if (kind < 54) begin
      plan_encoded(utf8d_pkg::CpWidth'($urandom_range(21'h10000, 21'h10FFFF)), 4);
    end else if (kind < 64) begin
      // Land on or just beside a combining-mark range bound.
      cp = mark_edges[4'($urandom_range(15))]
         + utf8d_pkg::CpWidth'($urandom_range(2)) - 21'd1;
      plan_encoded(cp, (cp < utf8d_pkg::MinThreeByte) ? 2 : 3);
    end else if (kind < 70) begin
      len = $urandom_range(2, 4);
      case (len)
        2:       cp = utf8d_pkg::CpWidth'($urandom_range(0, 21'h7F));
        3:       cp = utf8d_pkg::CpWidth'($urandom_range(0, 21'h7FF));
        default: cp = utf8d_pkg::CpWidth'($urandom_range(0, 21'hFFFF));
      endcase
      plan_encoded(cp, len);
    end else if (kind < 74) begin
      plan_encoded(utf8d_pkg::CpWidth'($urandom_range(utf8d_pkg::SurrogateLo,
                                                      utf8d_pkg::SurrogateHi)), 3);
    end else if (kind < 78) begin
      plan_encoded(utf8d_pkg::CpWidth'($urandom_range(21'h110000, 21'h1FFFFF)), 4);
    end else if (kind < 88) begin
      // Cut a good sequence short; the next sequence breaks it.
      len = $urandom_range(2, 4);
      case (len)
        2:       cp = utf8d_pkg::CpWidth'($urandom_range(21'h80, 21'h7FF));
        3:       cp = utf8d_pkg::CpWidth'($urandom_range(21'h800, 21'hD7FF));
        default: cp = utf8d_pkg::CpWidth'($urandom_range(21'h10000, 21'h10FFFF));
      endcase
      plan_encoded(cp, len);
      repeat ($urandom_range(1, len - 1)) void'(byte_plan.pop_back());
    end else begin
      byte_plan.push_back(8'($urandom_range(255)));
    end
  endtask

  // Set the idling pattern of one phase.
  task automatic set_idling(input int mode);
    case (mode)
      1:       begin idle_pct = 46; stall_pct = 0;  end
      2:       begin idle_pct = 0;  stall_pct = 46; end
      3:       begin idle_pct = 8;  stall_pct = 8;  end
      default: begin idle_pct = 0;  stall_pct = 0;  end
    endcase
  endtask

  initial begin
    logic [utf8d_pkg::CpWidth-1:0] repl_plan[5];
    logic [7:0]                    directed[$];

    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part, reset replacement value, no idling: ASCII extremes,
    // smallest two-byte form, a combining mark, U+FFFF, U+10FFFF, invalid
    // leads, overlong, surrogate, above U+10FFFF (four replacements), a
    // sequence broken by ASCII and one broken by a new lead that completes.
    directed = '{8'h00, 8'h7F, 8'hC2, 8'h80, 8'hCC, 8'h81, 8'hEF, 8'hBF, 8'hBF,
                 8'hF4, 8'h8F, 8'hBF, 8'hBF, 8'h80, 8'hFF, 8'hC1, 8'hBF,
                 8'hED, 8'hA0, 8'h80, 8'hF4, 8'h90, 8'h80, 8'h80,
                 8'hC3, 8'h41, 8'hE2, 8'h82, 8'hF0, 8'h9F, 8'h98, 8'h80};
    byte_plan = directed;
    set_idling(0);
    drive_plan();
    wait_drained();

    // Random phases: zero, all ones (out of range), a combining mark,
    // the top scalar, then a random legal value.
    repl_plan = '{21'h000000, 21'h1FFFFF, 21'h000301, utf8d_pkg::MaxScalar,
                  utf8d_pkg::CpWidth'($urandom_range(0, 21'h10FFFF))};
    for (int phase = 0; phase < 5; phase++) begin
      write_replacement(repl_plan[phase]);
      set_idling((phase + 1) % 4);
      while (byte_plan.size() < PhaseBytes) plan_random_sequence();
      drive_plan();
      wait_drained();
    end

    // Catch any stray result after the last one owed.
    repeat (4 * SettleCycles) @(negedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/utf8d_pkg.sv
rtl/core/utf8d_front.sv
rtl/core/utf8d_fifo.sv
rtl/core/utf8d_back.sv
rtl/core/utf8_stream_decoder.sv
dv/tb.sv
